// File: src/jsu_pkg.sv
// Shared types, constants and helper functions of the JSON string unescaper.
`default_nettype none

package jsu_pkg;

    // Parser phase, one-hot
    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_STR    = 8'b0000_0010,
        PH_ESC    = 8'b0000_0100,
        PH_HEX1   = 8'b0000_1000,
        PH_WANTBS = 8'b0001_0000,
        PH_WANTU  = 8'b0010_0000,
        PH_HEX2   = 8'b0100_0000,
        PH_BADHEX = 8'b1000_0000
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Status codes
    localparam logic [3:0] ST_NONE     = 4'd0;
    localparam logic [3:0] ST_NOQUOTE  = 4'd1;
    localparam logic [3:0] ST_CONTROL  = 4'd2;
    localparam logic [3:0] ST_INCESC   = 4'd3;
    localparam logic [3:0] ST_BADESC   = 4'd4;
    localparam logic [3:0] ST_INCUNI   = 4'd5;
    localparam logic [3:0] ST_BADHEX   = 4'd6;
    localparam logic [3:0] ST_MISSLOW  = 4'd7;
    localparam logic [3:0] ST_BADLOW   = 4'd8;
    localparam logic [3:0] ST_LONELOW  = 4'd9;
    localparam logic [3:0] ST_UNTERM   = 4'd10;

    // Characters of interest
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_BS_CTL = 8'h08;
    localparam logic [7:0] CH_FF_CTL = 8'h0C;

    // Surrogate ranges
    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;

    // Work descriptor from the front end to the output sequencer
    typedef struct packed {
        logic [3:0][7:0] data;        // UTF-8 bytes, first in entry 0
        logic [2:0]      n_data;      // 0 to 4 data bytes
        logic            has_tail;    // a close or error result follows
        logic [1:0]      tail_kind;
        logic [3:0]      tail_status;
    } desc_t;

    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      len;
    } utf8_t;

    // Hex digit value; bit 4 set when the byte is no hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] d;
        d = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) d = 5'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66) d = 5'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46) d = 5'(b - 8'h37);
        return d;
    endfunction

    // Encode a code point as 1 to 4 UTF-8 bytes
    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r.data = '0;
        if (cp <= 21'h7F) begin
            r.len = 3'd1;
            r.data[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            r.len = 3'd2;
            r.data[0] = {3'b110, cp[10:6]};
            r.data[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            r.len = 3'd3;
            r.data[0] = {4'b1110, cp[15:12]};
            r.data[1] = {2'b10, cp[11:6]};
            r.data[2] = {2'b10, cp[5:0]};
        end else begin
            r.len = 3'd4;
            r.data[0] = {5'b11110, cp[20:18]};
            r.data[1] = {2'b10, cp[17:12]};
            r.data[2] = {2'b10, cp[11:6]};
            r.data[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/jsu_front.sv
// Front end: parses one byte per cycle unless q_full; one descriptor per byte with results.
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_end,
    input  wire logic       q_full,
    output logic            q_push,
    output desc_t           q_desc
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [15:0] val_reg, val_next;
    logic [9:0]  hi_reg, hi_next;

    logic        accept;
    logic        cp_en;
    logic        raw_en;
    logic [20:0] cp_val;
    logic        tail;
    logic [1:0]  tail_kind;
    logic [3:0]  tail_status;
    logic [4:0]  dig;
    logic [15:0] hv;
    logic [2:0]  cnt_inc;
    utf8_t       enc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign cnt_inc  = cnt_reg + 3'd1;
    assign hv       = {val_reg[11:0], dig[3:0]};

    // Decode the byte against the current phase
    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        val_next    = val_reg;
        hi_next     = hi_reg;
        cp_en       = 1'b0;
        raw_en      = 1'b0;
        cp_val      = '0;
        tail        = 1'b0;
        tail_kind   = KIND_ERROR;
        tail_status = ST_NONE;
        dig         = (phase_reg == PH_BADHEX) ? 5'h10 : hex_digit(in_byte);

        unique case (phase_reg)
            PH_IDLE: begin
                if (in_byte == CH_SPACE || in_byte == CH_TAB ||
                    in_byte == CH_CR || in_byte == CH_LF) begin
                    if (in_end) begin
                        tail = 1'b1;
                        tail_status = ST_NOQUOTE;
                    end
                end else if (in_byte == CH_QUOTE) begin
                    phase_next = PH_STR;
                    if (in_end) begin
                        tail = 1'b1;
                        tail_status = ST_UNTERM;
                        phase_next = PH_IDLE;
                    end
                end else begin
                    tail = 1'b1;
                    tail_status = ST_NOQUOTE;
                end
            end
            PH_STR: begin
                if (in_byte == CH_QUOTE) begin
                    tail = 1'b1;
                    tail_kind = KIND_CLOSE;
                    phase_next = PH_IDLE;
                end else if (in_byte < CH_SPACE) begin
                    tail = 1'b1;
                    tail_status = ST_CONTROL;
                    phase_next = PH_IDLE;
                end else if (in_byte == CH_BSLASH) begin
                    if (in_end) begin
                        tail = 1'b1;
                        tail_status = ST_INCESC;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_ESC;
                    end
                end else begin
                    // Plain text bytes, including 0x80 and above, pass unchanged
                    raw_en = 1'b1;
                    if (in_end) begin
                        tail = 1'b1;
                        tail_status = ST_UNTERM;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_ESC: begin
                phase_next = PH_STR;
                priority case (in_byte)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                        cp_en = 1'b1;
                        cp_val = 21'(in_byte);
                    end
                    CH_B: begin cp_en = 1'b1; cp_val = 21'(CH_BS_CTL); end
                    CH_F: begin cp_en = 1'b1; cp_val = 21'(CH_FF_CTL); end
                    CH_N: begin cp_en = 1'b1; cp_val = 21'(CH_LF); end
                    CH_R: begin cp_en = 1'b1; cp_val = 21'(CH_CR); end
                    CH_T: begin cp_en = 1'b1; cp_val = 21'(CH_TAB); end
                    CH_U: begin
                        phase_next = PH_HEX1;
                        cnt_next = '0;
                        val_next = '0;
                        if (in_end) begin
                            tail = 1'b1;
                            tail_status = ST_INCUNI;
                            phase_next = PH_IDLE;
                        end
                    end
                    default: begin
                        tail = 1'b1;
                        tail_status = ST_BADESC;
                        phase_next = PH_IDLE;
                    end
                endcase
                if (cp_en && in_end) begin
                    tail = 1'b1;
                    tail_status = ST_UNTERM;
                    phase_next = PH_IDLE;
                end
            end
            PH_HEX1, PH_HEX2, PH_BADHEX: begin
                if (dig[4]) begin
                    // Not a digit: consume the remaining slots, then report
                    if (cnt_reg >= 3'd3) begin
                        tail = 1'b1;
                        tail_status = ST_BADHEX;
                        phase_next = PH_IDLE;
                    end else if (in_end) begin
                        tail = 1'b1;
                        tail_status = ST_INCUNI;
                        phase_next = PH_IDLE;
                    end else begin
                        cnt_next = cnt_inc;
                        phase_next = PH_BADHEX;
                    end
                end else begin
                    val_next = hv;
                    cnt_next = cnt_inc;
                    if (cnt_inc < 3'd4) begin
                        if (in_end) begin
                            tail = 1'b1;
                            tail_status = ST_INCUNI;
                            phase_next = PH_IDLE;
                        end
                    end else if (phase_reg == PH_HEX1) begin
                        if (hv >= HIGH_FIRST && hv <= HIGH_LAST) begin
                            hi_next = hv[9:0];
                            if (in_end) begin
                                tail = 1'b1;
                                tail_status = ST_MISSLOW;
                                phase_next = PH_IDLE;
                            end else begin
                                phase_next = PH_WANTBS;
                            end
                        end else if (hv >= LOW_FIRST && hv <= LOW_LAST) begin
                            tail = 1'b1;
                            tail_status = ST_LONELOW;
                            phase_next = PH_IDLE;
                        end else begin
                            cp_en = 1'b1;
                            cp_val = 21'(hv);
                            phase_next = PH_STR;
                        end
                    end else begin
                        if (hv < LOW_FIRST || hv > LOW_LAST) begin
                            tail = 1'b1;
                            tail_status = ST_BADLOW;
                            phase_next = PH_IDLE;
                        end else begin
                            cp_en = 1'b1;
                            cp_val = {11'(hi_reg) + 11'd64, hv[9:0]};
                            phase_next = PH_STR;
                        end
                    end
                    if (cp_en && in_end) begin
                        tail = 1'b1;
                        tail_status = ST_UNTERM;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_WANTBS: begin
                if (in_byte == CH_BSLASH && !in_end) begin
                    phase_next = PH_WANTU;
                end else begin
                    tail = 1'b1;
                    tail_status = ST_MISSLOW;
                    phase_next = PH_IDLE;
                end
            end
            PH_WANTU: begin
                if (in_byte != CH_U) begin
                    tail = 1'b1;
                    tail_status = ST_MISSLOW;
                    phase_next = PH_IDLE;
                end else if (in_end) begin
                    tail = 1'b1;
                    tail_status = ST_INCUNI;
                    phase_next = PH_IDLE;
                end else begin
                    phase_next = PH_HEX2;
                    cnt_next = '0;
                    val_next = '0;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Build the descriptor
    always_comb begin
        enc = utf8_encode(cp_val);
        q_desc.data        = raw_en ? {24'h000000, in_byte} : enc.data;
        q_desc.n_data      = raw_en ? 3'd1 : (cp_en ? enc.len : 3'd0);
        q_desc.has_tail    = tail;
        q_desc.tail_kind   = tail_kind;
        q_desc.tail_status = (tail_kind == KIND_ERROR) ? tail_status : ST_NONE;
    end

    assign q_push = accept && (cp_en || raw_en || tail);

    // Advance parser state on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            val_reg   <= '0;
            hi_reg    <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            val_reg   <= val_next;
            hi_reg    <= hi_next;
        end
    end

endmodule

`default_nettype wire

// File: src/jsu_queue.sv
// Two-entry descriptor queue between the front end and the output sequencer.
`default_nettype none

module jsu_queue
    import jsu_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire desc_t push_desc,
    output logic       full,
    input  wire logic  pop,
    output logic       head_valid,
    output desc_t      head_desc
);

    desc_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_desc  = entry_reg[rd_ptr_reg];

    // Pointer and fill updates
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store descriptors
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

// File: src/jsu_back.sv
// Output sequencer: expands each descriptor into results, one per cycle while the output is taken.
`default_nettype none

module jsu_back
    import jsu_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  head_valid,
    input  wire desc_t head_desc,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] out_kind,
    output logic [3:0] out_status,
    output logic       out_last
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic [1:0] kind_reg, kind_next;
    logic [3:0] status_reg, status_next;
    logic       last_reg, last_next;
    logic       load;
    logic       is_last;
    logic [2:0] total;

    assign total   = head_desc.n_data + 3'(head_desc.has_tail);
    assign is_last = (idx_reg == total - 3'd1);
    assign load    = head_valid && (!valid_reg || out_ready);
    assign pop     = load && is_last;

    // Select the next result of the head descriptor
    always_comb begin
        valid_next  = valid_reg && !out_ready;
        idx_next    = idx_reg;
        byte_next   = byte_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        last_next   = last_reg;
        if (load) begin
            valid_next = 1'b1;
            last_next  = is_last;
            idx_next   = is_last ? 3'd0 : idx_reg + 3'd1;
            if (idx_reg < head_desc.n_data) begin
                byte_next   = head_desc.data[idx_reg[1:0]];
                kind_next   = KIND_DATA;
                status_next = ST_NONE;
            end else begin
                byte_next   = 8'h00;
                kind_next   = head_desc.tail_kind;
                status_next = head_desc.tail_status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Hold the payload until taken
    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        kind_reg   <= kind_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign out_kind   = kind_reg;
    assign out_status = status_reg;
    assign out_last   = last_reg;

endmodule

`default_nettype wire

// File: src/json_string_unescape_to_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
//  Channel | Dir | tdata          | tuser                    | tlast
//  s_      | in  | [7:0] in_byte  | -                        | in_end
//  m_      | out | [7:0] out_byte | [1:0] kind, [5:2] status | run_end
//
// The front end takes one text byte per cycle and turns it into at most one
// descriptor; the sequencer sends one result per cycle while m_tready is high,
// so a code point of n UTF-8 bytes plus a close or error result gives n + 1
// results. The two-entry descriptor queue absorbs short bursts; input stalls
// only when it is full. Reset (aresetn low, synchronous) returns to idle and
// empties the queue and output register.
`default_nettype none

module json_string_unescape_to_utf8
    import jsu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [5:0]      m_tuser,   // [1:0] kind, [5:2] status
    output logic            m_tlast
);

    logic  q_full;
    logic  q_push;
    desc_t q_desc;
    logic  q_pop;
    logic  q_head_valid;
    desc_t q_head;
    logic [1:0] out_kind;
    logic [3:0] out_status;

    jsu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_end   (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_desc   (q_desc)
    );

    jsu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (q_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_desc  (q_head)
    );

    jsu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_desc  (q_head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_kind   (out_kind),
        .out_status (out_status),
        .out_last   (m_tlast)
    );

    assign m_tuser = {out_status, out_kind};

endmodule

`default_nettype wire

// File: src/jsu_checker.sv
// Port-level checker for the JSON string unescaper, bound to the top level.
`default_nettype none

module jsu_checker
    import jsu_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [5:0] m_tuser,
    input wire logic       m_tlast
);

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // Close and error results end the run of their byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] != KIND_DATA |-> m_tlast && m_tdata == 8'h00)
        else $error("close or error not last or carries data");

    // Status only on errors, and a valid code there
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[1:0] == KIND_ERROR) ?
            (m_tuser[5:2] != ST_NONE && m_tuser[5:2] <= ST_UNTERM) :
            (m_tuser[5:2] == ST_NONE && m_tuser[1:0] != 2'd3))
        else $error("bad kind or status");

    // Output empty after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind json_string_unescape_to_utf8 jsu_checker u_jsu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
